// ===== rtl/life_pkg.sv =====
// Shared types and constants for the toroidal life grid.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package life_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    // sweep step runs 0 .. GRID_HEIGHT + 2
    localparam int STEP_W = $clog2(GRID_HEIGHT + 3);

    typedef logic [GRID_WIDTH-1:0] row_bits_t;

    typedef enum logic [1:0] {
        MODE_SET = 2'd0,
        MODE_GET = 2'd1,
        MODE_ADV = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_GET_RD,
        ST_ADV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;     // latch the incoming transaction, rewind the sweep
        logic rd_item;  // read the addressed row
        logic wr_item;  // write back the addressed row with the cell set
        logic sweep;    // one step of the generation sweep
        logic finish;   // present the result
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/life_ctrl.sv =====
// Controller FSM for the life grid: sequences set, get and advance.
// Depends on life_pkg; drives life_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module life_ctrl
    import life_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] mode,
    input  wire dp_status_t status,
    output logic            busy,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode_t'(mode))
                        MODE_SET: state_next = ST_SET_RD;
                        MODE_GET: state_next = ST_GET_RD;
                        MODE_ADV: state_next = ST_ADV;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SET_RD: state_next = ST_SET_WR;
            ST_SET_WR: state_next = ST_FINISH;
            ST_GET_RD: state_next = ST_FINISH;
            ST_ADV:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SET_RD: cmd.rd_item = 1'b1;
            ST_SET_WR: cmd.wr_item = 1'b1;
            ST_GET_RD: cmd.rd_item = 1'b1;
            ST_ADV:    cmd.sweep   = 1'b1;
            ST_FINISH: cmd.finish  = 1'b1;
            default:   busy        = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/life_dp.sv =====
// Datapath for the life grid: row memory with valid bits, item registers,
// sweep window and next-generation row logic. Depends on life_pkg.
`timescale 1ns / 1ps
`default_nettype none

module life_dp
    import life_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] mode,
    input  wire logic [5:0] col,
    input  wire logic [5:0] row,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    output logic            done,
    output logic            alive
);

    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(GRID_HEIGHT - 1);
    localparam logic [STEP_W-1:0] STEP_ONE   = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_TWO   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_THREE = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_RDEND = STEP_W'(GRID_HEIGHT);
    localparam logic [STEP_W-1:0] STEP_MID   = STEP_W'(GRID_HEIGHT + 1);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(GRID_HEIGHT + 2);

    function automatic row_bits_t next_row(row_bits_t above, row_bits_t cur,
                                           row_bits_t below);
        row_bits_t  res;
        int         l;
        int         r;
        logic [3:0] n;
        res = '0;
        for (int c = 0; c < GRID_WIDTH; c++)
        begin
            l = (c == 0) ? GRID_WIDTH - 1 : c - 1;
            r = (c == GRID_WIDTH - 1) ? 0 : c + 1;
            n = 4'(above[l]) + 4'(above[c]) + 4'(above[r])
              + 4'(cur[l]) + 4'(cur[r])
              + 4'(below[l]) + 4'(below[c]) + 4'(below[r]);
            res[c] = (n == 4'd3) || (cur[c] && (n == 4'd2));
        end
        return res;
    endfunction

    // row storage; rows never written read as dead
    row_bits_t mem [GRID_HEIGHT];
    logic      valid_reg [GRID_HEIGHT];
    row_bits_t rd_data_reg;
    logic      rd_valid_reg;
    row_bits_t rd_q;

    mode_t             mode_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              inside_reg;

    logic [STEP_W-1:0] step_reg;
    row_bits_t         above_reg;
    row_bits_t         cur_reg;
    row_bits_t         top_reg;

    logic              done_reg;
    logic              alive_reg;
    logic              alive_next;

    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    row_bits_t         wr_data;
    row_bits_t         below;
    logic              in_inside;

    assign rd_q      = rd_valid_reg ? rd_data_reg : '0;
    assign in_inside = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
    assign below     = (step_reg == STEP_LAST) ? top_reg : rd_q;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = row_reg;
        wr_en   = 1'b0;
        wr_addr = row_reg;
        wr_data = rd_q | (row_bits_t'(1) << col_reg);
        if (cmd.rd_item)
        begin
            rd_en = 1'b1;
        end
        if (cmd.wr_item && inside_reg)
        begin
            wr_en = 1'b1;
        end
        if (cmd.sweep)
        begin
            // reads: last row first, then rows 0 .. H-1
            if (step_reg == '0)
            begin
                rd_en   = 1'b1;
                rd_addr = LAST_ROW;
            end
            else if (step_reg <= STEP_RDEND)
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_W'(step_reg - STEP_ONE);
            end
            // writes trail the reads; last row wraps to saved row 0
            if (step_reg inside {[STEP_THREE:STEP_MID]})
            begin
                wr_en   = 1'b1;
                wr_addr = ROW_W'(step_reg - STEP_THREE);
                wr_data = next_row(above_reg, cur_reg, below);
            end
            else if (step_reg == STEP_LAST)
            begin
                wr_en   = 1'b1;
                wr_addr = LAST_ROW;
                wr_data = next_row(above_reg, cur_reg, below);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_HEIGHT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // item and sweep window registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode_t'(mode);
            col_reg    <= COL_W'(col);
            row_reg    <= ROW_W'(row);
            inside_reg <= in_inside;
        end
        if (cmd.sweep)
        begin
            if (step_reg == STEP_ONE)
            begin
                above_reg <= rd_q;
            end
            else if (step_reg == STEP_TWO)
            begin
                cur_reg <= rd_q;
                top_reg <= rd_q;
            end
            else if (step_reg inside {[STEP_THREE:STEP_MID]})
            begin
                above_reg <= cur_reg;
                cur_reg   <= rd_q;
            end
        end
    end

    assign alive_next = (mode_reg == MODE_GET) && inside_reg && rd_q[col_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            done_reg  <= 1'b0;
            alive_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.sweep)
            begin
                step_reg <= step_reg + STEP_ONE;
            end
            done_reg  <= cmd.finish;
            alive_reg <= cmd.finish ? alive_next : 1'b0;
        end
    end

    assign status.sweep_last = (step_reg == STEP_LAST);
    assign done  = done_reg;
    assign alive = alive_reg;

endmodule

`default_nettype wire

// ===== rtl/life_cellular_automaton_grid_top.sv =====
// Top level of the toroidal life grid: controller plus datapath.
// Depends on life_pkg, life_ctrl and life_dp.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low; mode, col and row are sampled there. Mode 0 sets cell
//   (col,row) alive, mode 1 reads it, mode 2 advances the whole grid one
//   generation, mode 3 does nothing. Set or read of a cell outside the grid
//   does nothing and answers 0.
//   Result channel: exactly one result per transaction, on alive for the
//   single cycle that done is high. The receiver cannot stall it; results
//   are never held back or repeated.
//   Before done, a read passes a row read, a set a row read and a row write,
//   an advance a sweep over all rows, and every mode a finish state. The
//   advance is bound by the row memory port: one row read and one row written
//   per cycle, with the row above, current row and saved row 0 in a sliding window.
//   busy drops in the cycle done is shown, so the next transaction may be
//   issued then.
//   Reset: asynchronous, active low. All cells read dead after reset through
//   per-row valid bits; no clearing pass is needed.
module life_cellular_automaton_grid_top
    import life_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] mode,
    input  wire logic [5:0] col,
    input  wire logic [5:0] row,
    output logic            busy,
    output logic            done,
    output logic            alive
);

    dp_cmd_t    cmd;
    dp_status_t status;

    life_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    life_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (mode),
        .col    (col),
        .row    (row),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .alive  (alive)
    );

    // a result always ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in progress");

    // a result is a single-cycle strobe
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    // busy only ends by delivering a result
    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy ended without a result");

endmodule

`default_nettype wire
